/* src/assert_macros.svh */
// Assertion helpers for the RTL that carries checks; the top level includes them.
// Both macros expect signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MRF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define MRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/mrf_pkg.sv */
package mrf_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 20;
  localparam int PROD_BITS   = 2 * WORD_BITS;
  localparam int DIV_BITS    = WORD_BITS + FRAC_BITS;
  localparam int DIV_CW      = $clog2(DIV_BITS);
  localparam int SQ_STEPS    = (DIV_BITS + 1) / 2;
  localparam int SQ_CW       = $clog2(SQ_STEPS);
  localparam int RAD_BITS    = 2 * SQ_STEPS;
  localparam int SQ_REM_BITS = SQ_STEPS + 1;
  localparam int SQ_TRY_BITS = SQ_STEPS + 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef word_t [2:0] vec3_t;

  // Left and right face states of one interface.
  typedef struct packed {
    vec3_t ul;
    vec3_t ur;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV_U,
    BK_MUL_RU,
    BK_MUL_T,
    BK_MUL_P,
    BK_MUL_GP,
    BK_DIV_C,
    BK_SQRT,
    BK_FACE_END,
    BK_DISS,
    BK_DONE
  } bk_state_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] WORD_ONE = {{(WORD_BITS-1){1'b0}}, 1'b1};
  localparam longint unsigned GAMMA_RAW = ((64'd7 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam longint unsigned GM1_RAW   = ((64'd2 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam word_t GAMMA_Q = word_t'(GAMMA_RAW);
  localparam word_t GM1_Q   = word_t'(GM1_RAW);

  function automatic word_t sadd(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
    return s[WORD_BITS-1:0];
  endfunction

  // Halving that truncates toward zero.
  function automatic word_t half(input word_t a);
    logic [WORD_BITS-1:0] s;
    s = a + {{(WORD_BITS-1){1'b0}}, a[WORD_BITS-1]};
    return word_t'($signed(s) >>> 1);
  endfunction

  function automatic logic [WORD_BITS-1:0] smag(input word_t a);
    logic [WORD_BITS-1:0] t;
    t = a;
    return t[WORD_BITS-1] ? (~t + WORD_ONE) : t;
  endfunction

  function automatic word_t abs_sat(input word_t a);
    if (a == WMIN) return WMAX;
    return (a < 0) ? -a : a;
  endfunction

  // Signed result from sign and wide magnitude, saturated to the word range.
  function automatic word_t sat_mag(input logic neg, input logic [PROD_BITS-1:0] m);
    logic [PROD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] lo;
    lim = {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}}
        + {{(PROD_BITS-1){1'b0}}, neg};
    lo  = m[WORD_BITS-1:0];
    if (m > lim) return neg ? WMIN : WMAX;
    return neg ? word_t'(~lo + WORD_ONE) : word_t'(lo);
  endfunction

  function automatic word_t qmul(input word_t a, input word_t b);
    logic [PROD_BITS-1:0] p;
    p = {{WORD_BITS{1'b0}}, smag(a)} * {{WORD_BITS{1'b0}}, smag(b)};
    return sat_mag(a[WORD_BITS-1] ^ b[WORD_BITS-1], p >> FRAC_BITS);
  endfunction

  function automatic word_t minmod2(input word_t a, input word_t b);
    if (a > 0 && b > 0) return (a < b) ? a : b;
    if (a < 0 && b < 0) return (a > b) ? a : b;
    return '0;
  endfunction

  function automatic word_t minmod3(input word_t x, input word_t y, input word_t z);
    word_t m;
    if (x > 0 && y > 0 && z > 0) begin
      m = (x < y) ? x : y;
      return (m < z) ? m : z;
    end
    if (x < 0 && y < 0 && z < 0) begin
      m = (x > y) ? x : y;
      return (m > z) ? m : z;
    end
    return '0;
  endfunction

endpackage

/* src/mrf_front.sv */
module mrf_front
  import mrf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  word_t   in_density,
  input  word_t   in_momentum,
  input  word_t   in_energy,
  input  logic    in_middle_troubled,
  input  logic    in_row_start,
  input  q_stat_t q_stat,
  output logic    q_push,
  output job_t    q_job
);

  vec3_t      older_r, mid_r, slope_r;
  vec3_t      cur, slope;
  logic [1:0] cnt_r, cnt_nxt, n;
  logic       accept;
  word_t      a, b;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    cur[0] = in_density;
    cur[1] = in_momentum;
    cur[2] = in_energy;
    n      = in_row_start ? 2'd0 : cnt_r;
    for (int k = 0; k < 3; k++) begin
      a = ssub(mid_r[k], older_r[k]);
      b = ssub(cur[k], mid_r[k]);
      if (!n[1]) begin
        slope[k] = '0;
      end else if (in_middle_troubled) begin
        slope[k] = minmod2(a, b);
      end else begin
        slope[k] = minmod3(sadd(a, a), sadd(b, b), half(sadd(a, b)));
      end
      q_job.ul[k] = sadd(older_r[k], half(slope_r[k]));
      q_job.ur[k] = ssub(mid_r[k], half(slope[k]));
    end
    q_push  = accept && (&n);
    cnt_nxt = (&n) ? n : n + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      older_r <= '0;
      mid_r   <= '0;
      slope_r <= '0;
    end else if (accept) begin
      cnt_r   <= cnt_nxt;
      older_r <= mid_r;
      mid_r   <= cur;
      slope_r <= slope;
    end
  end

endmodule

/* src/mrf_queue.sv */
module mrf_queue
  import mrf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head       = mem_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

endmodule

/* src/mrf_div.sv */
module mrf_div
  import mrf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t a,
  input  word_t b,
  output logic  done,
  output word_t q
);

  // Restoring division of |a| * 2^FRAC by a positive divisor, one bit a cycle.
  logic                  busy_r, done_r, neg_r;
  logic [DIV_CW-1:0]     cnt_r;
  logic [DIV_BITS-1:0]   num_r, quo_r;
  logic [WORD_BITS-1:0]  rem_r, d_r;
  logic [WORD_BITS:0]    rem2, diff;
  logic                  ge;

  assign rem2 = {rem_r, num_r[DIV_BITS-1]};
  assign diff = rem2 - {1'b0, d_r};
  assign ge   = (rem2 >= {1'b0, d_r});
  assign done = done_r;
  assign q    = sat_mag(neg_r, PROD_BITS'(quo_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - DIV_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {smag(a), {FRAC_BITS{1'b0}}};
      d_r   <= b;
      neg_r <= a[WORD_BITS-1];
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_BITS-2:0], 1'b0};
      rem_r <= ge ? diff[WORD_BITS-1:0] : rem2[WORD_BITS-1:0];
      quo_r <= {quo_r[DIV_BITS-2:0], ge};
    end
  end

endmodule

/* src/mrf_sqrt.sv */
module mrf_sqrt
  import mrf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t x,
  output logic  done,
  output word_t root
);

  // Digit-by-digit square root of x * 2^FRAC, two radicand bits a cycle.
  logic                   busy_r, done_r;
  logic [SQ_CW-1:0]       cnt_r;
  logic [RAD_BITS-1:0]    rad_r;
  logic [SQ_REM_BITS-1:0] rem_r;
  logic [SQ_STEPS-1:0]    root_r;
  logic [SQ_TRY_BITS-1:0] rem2, trial, diff;
  logic                   ge;

  assign rem2  = {rem_r, rad_r[RAD_BITS-1 -: 2]};
  assign trial = SQ_TRY_BITS'({root_r, 2'b01});
  assign diff  = rem2 - trial;
  assign ge    = (rem2 >= trial);
  assign done  = done_r;
  assign root  = word_t'(root_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SQ_CW'(SQ_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - SQ_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_BITS'({x, {FRAC_BITS{1'b0}}});
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_BITS-3:0], 2'b00};
      rem_r  <= ge ? diff[SQ_REM_BITS-1:0] : rem2[SQ_REM_BITS-1:0];
      root_r <= {root_r[SQ_STEPS-2:0], ge};
    end
  end

endmodule

/* src/mrf_back.sv */
module mrf_back
  import mrf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_stat_t q_stat,
  input  job_t    q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output word_t   out_flux_density,
  output word_t   out_flux_momentum,
  output word_t   out_flux_energy,
  output logic    out_fault
);

  bk_state_t  state_r, state_nxt;
  logic       fsel_r, bad_r, out_valid_r, out_fault_r;
  logic [1:0] k_r;
  word_t      u_r, ru_r, t_r, p_r, c_r;
  vec3_t      face_f_r [2];
  word_t      spd_r [2];
  vec3_t      acc_r, out_r;

  vec3_t      s;
  word_t      r, m, e, smax;
  word_t      mul_a, mul_b, mul_y;
  logic       r_pos, div_start, div_done, sqrt_start, sqrt_done, out_load;
  word_t      div_a, div_q, sqrt_root;

  assign s     = fsel_r ? q_head.ur : q_head.ul;
  assign r     = s[0];
  assign m     = s[1];
  assign e     = s[2];
  assign r_pos = (r > 0);
  assign smax  = (spd_r[0] > spd_r[1]) ? spd_r[0] : spd_r[1];
  assign mul_y = qmul(mul_a, mul_b);

  mrf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (r),
    .done  (div_done),
    .q     (div_q)
  );

  mrf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (div_q),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:     if (!q_stat.empty) state_nxt = BK_LOAD;
      BK_LOAD:     state_nxt = r_pos ? BK_DIV_U : BK_MUL_RU;
      BK_DIV_U:    if (div_done) state_nxt = BK_MUL_RU;
      BK_MUL_RU:   state_nxt = BK_MUL_T;
      BK_MUL_T:    state_nxt = BK_MUL_P;
      BK_MUL_P:    state_nxt = BK_MUL_GP;
      BK_MUL_GP:   state_nxt = (r_pos && !p_r[WORD_BITS-1]) ? BK_DIV_C : BK_FACE_END;
      BK_DIV_C:    if (div_done) state_nxt = BK_SQRT;
      BK_SQRT:     if (sqrt_done) state_nxt = BK_FACE_END;
      BK_FACE_END: state_nxt = fsel_r ? BK_DISS : BK_LOAD;
      BK_DISS:     if (k_r == 2'd2) state_nxt = BK_DONE;
      BK_DONE:     if (out_load) state_nxt = BK_IDLE;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    mul_a      = r;
    mul_b      = u_r;
    div_start  = 1'b0;
    div_a      = m;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      BK_LOAD: div_start = r_pos;
      BK_MUL_RU: begin
        mul_a = r;
        mul_b = u_r;
      end
      BK_MUL_T: begin
        mul_a = ru_r;
        mul_b = u_r;
      end
      BK_MUL_P: begin
        mul_a = GM1_Q;
        mul_b = ssub(e, half(t_r));
      end
      BK_MUL_GP: begin
        mul_a     = GAMMA_Q;
        mul_b     = p_r;
        div_a     = mul_y;
        div_start = r_pos && !p_r[WORD_BITS-1];
      end
      BK_DIV_C: sqrt_start = div_done;
      BK_FACE_END: begin
        mul_a = u_r;
        mul_b = sadd(e, p_r);
      end
      BK_DISS: begin
        mul_a = smax;
        mul_b = ssub(q_head.ur[k_r], q_head.ul[k_r]);
      end
      BK_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign q_pop = out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fsel_r      <= 1'b0;
      bad_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        BK_IDLE: begin
          fsel_r <= 1'b0;
          bad_r  <= 1'b0;
        end
        BK_LOAD:     if (!r_pos) bad_r <= 1'b1;
        BK_MUL_GP:   if (p_r[WORD_BITS-1]) bad_r <= 1'b1;
        BK_FACE_END: begin
          fsel_r <= 1'b1;
          k_r    <= '0;
        end
        BK_DISS:     k_r <= k_r + 2'd1;
        default: ;
      endcase
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_LOAD:   if (!r_pos) u_r <= '0;
      BK_DIV_U:  if (div_done) u_r <= div_q;
      BK_MUL_RU: ru_r <= mul_y;
      BK_MUL_T:  t_r <= mul_y;
      BK_MUL_P:  p_r <= mul_y;
      BK_MUL_GP: if (!(r_pos && !p_r[WORD_BITS-1])) c_r <= '0;
      BK_SQRT:   if (sqrt_done) c_r <= sqrt_root;
      BK_FACE_END: begin
        face_f_r[fsel_r][0] <= ru_r;
        face_f_r[fsel_r][1] <= sadd(t_r, p_r);
        face_f_r[fsel_r][2] <= mul_y;
        spd_r[fsel_r]       <= sadd(abs_sat(u_r), c_r);
      end
      BK_DISS: acc_r[k_r] <= ssub(half(sadd(face_f_r[0][k_r], face_f_r[1][k_r])),
                                  half(mul_y));
      default: ;
    endcase
    if (out_load) begin
      out_r       <= acc_r;
      out_fault_r <= bad_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_flux_density  = out_r[0];
  assign out_flux_momentum = out_r[1];
  assign out_flux_energy   = out_r[2];
  assign out_fault         = out_fault_r;

endmodule

/* src/muscl_rusanov_interface_flux.sv */
// MUSCL reconstruction with a Rusanov interface flux for the 1-D Euler
// equations, fed one cell word per accepted input and returning one flux word
// per interface from the fourth cell of a row onward. The front end takes a
// cell every cycle while its two-entry job queue has room; it limits the slope
// of the middle cell (minmod when flagged troubled, MC otherwise) and builds
// both face states at once. The back end works one interface at a time with a
// single shared multiplier, a one-bit-per-cycle divider and a two-bit-per-cycle
// square root. A face with positive density and pressure takes a load step, a
// division for the velocity, four multiplier steps, a second division for
// gamma times pressure over density, the square root for the sound speed and a
// face-end step; with negative pressure the second division and the square
// root are skipped, and with non-positive density the first division is also
// skipped and velocity and sound speed are zero. After both faces the back end
// forms the dissipation one flux component at a time and loads the output
// register, waiting while the output stalls; it takes no new interface before
// then. The queue holds up to two jobs and the output register one result.
// Values are signed Q12.20 and every intermediate result saturates; a
// non-positive face density or a negative face pressure raises the fault bit.
`include "assert_macros.svh"

module muscl_rusanov_interface_flux
  import mrf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t in_density,
  input  word_t in_momentum,
  input  word_t in_energy,
  input  logic  in_middle_troubled,
  input  logic  in_row_start,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t out_flux_density,
  output word_t out_flux_momentum,
  output word_t out_flux_energy,
  output logic  out_fault
);

  // Handshake between the job queue and the front and back ends.
  q_stat_t q_stat;
  logic    q_push, q_pop;
  job_t    q_job, q_head;

  // The front end owns the cell window and slope limiting.
  mrf_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_density         (in_density),
    .in_momentum        (in_momentum),
    .in_energy          (in_energy),
    .in_middle_troubled (in_middle_troubled),
    .in_row_start       (in_row_start),
    .q_stat             (q_stat),
    .q_push             (q_push),
    .q_job              (q_job)
  );

  // The queue lets the front keep taking cells while the back end iterates.
  mrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // The back end evaluates both faces and forms the flux word.
  mrf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_flux_density  (out_flux_density),
    .out_flux_momentum (out_flux_momentum),
    .out_flux_energy   (out_flux_energy),
    .out_fault         (out_fault)
  );

  // A job is never written into a full queue, nor taken from an empty one.
  `MRF_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full)
  `MRF_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty)
  // The first cell of a row never produces an interface job.
  `MRF_ASSERT_NOW(a_row_start_quiet, in_valid && !in_stall && in_row_start, !q_push)
  // A full queue stays full until the back end releases a job.
  `MRF_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full)

endmodule
